// ===== design/sdm_pkg.sv =====
// sdm_pkg: shared codes, field widths and status struct for the sieve divisor marker
// no dependencies; used by the interfaces, the remainder unit and the top level

package sdm_pkg;

    // width of the item_value field on the request channel
    localparam int ITEM_W = 32;

    // request mode codes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_TEST   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOW  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // smallest value accepted into the prime table
    localparam int MIN_PRIME = 2;

    // status from the serial remainder unit to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } t_rem_stat;

endpackage

// ===== design/sdm_if.sv =====
// sdm_req_if / sdm_res_if: valid-ready channels of the sieve divisor marker
// depends on sdm_pkg for the field widths

interface sdm_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 mode;
    logic [sdm_pkg::ITEM_W-1:0] item_value;
    logic                       flag_in;

    modport source (output valid, mode, item_value, flag_in, input ready);
    modport sink   (input valid, mode, item_value, flag_in, output ready);
endinterface

interface sdm_res_if;
    logic       valid;
    logic       ready;
    logic       flag_out;
    logic [1:0] status;

    modport source (output valid, flag_out, status, input ready);
    modport sink   (input valid, flag_out, status, output ready);
endinterface

// ===== design/sdm_ram.sv =====
// sdm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies

module sdm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/sdm_rem.sv =====
// sdm_rem: bit-serial restoring remainder unit, one dividend bit per cycle
// depends on sdm_pkg for the status struct

module sdm_rem #(
    parameter int VW = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [VW-1:0]     i_dividend,
    input  logic [VW-1:0]     i_divisor,
    output sdm_pkg::t_rem_stat o_stat
);

    localparam int CNT_W = $clog2(VW + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_done;
    logic [VW-1:0]    r_rem;
    logic [VW-1:0]    r_shift;
    logic [VW-1:0]    r_div;
    logic [VW:0]      n_trial;
    logic             n_fits;

    // trial subtract of the divisor from the remainder with the next dividend bit
    always_comb begin
        n_trial = {r_rem, r_shift[VW-1]};
        n_fits  = (n_trial >= {1'b0, r_div});
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(VW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and dividend shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= '0;
            r_shift <= i_dividend;
            r_div   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_shift <= {r_shift[VW-2:0], 1'b0};
            if (n_fits) begin
                r_rem <= VW'(n_trial - {1'b0, r_div});
            end else begin
                r_rem <= n_trial[VW-1:0];
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_stat.zero = (r_rem == '0);

endmodule

// ===== design/sieve_divisor_marker.sv =====
// sieve_divisor_marker: top level, prime table, walk sequencer and result register
// depends on sdm_pkg, sdm_if, sdm_ram and sdm_rem
//
// Usage:
//   i_req carries requests: mode clear empties the prime table, mode append
//   stores one prime (below 2 gives status low, a full table gives status
//   full), mode test checks a candidate against the stored primes.
//   o_res returns exactly one result per request: flag_out and status.
//   Clear, append, unused modes, a test with the flag clear and a test on an
//   empty table give their result in the cycle after the request is taken.
//   A test with the flag set walks the table, one prime at a time: for each
//   prime the sequencer reads the table, fetches the prime, runs the
//   bit-serial remainder unit on min(VALUE_BITS,32) bits and checks the remainder.
//   The walk stops early at the first prime that divides the candidate.
//   Requests are taken only while no walk is running and the result register
//   is empty or being emptied in the same cycle; a stalled receiver holds
//   the result and so blocks further requests.
//   Reset empties the table count and drops any pending result; table
//   contents are not cleared, entries past the count are never read.

module sieve_divisor_marker #(
    parameter int MAX_PRIMES = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sdm_req_if.sink          i_req,
    sdm_res_if.source        o_res
);

    localparam int VW     = (VALUE_BITS < sdm_pkg::ITEM_W) ? VALUE_BITS : sdm_pkg::ITEM_W;
    localparam int AW     = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int CW     = $clog2(MAX_PRIMES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FETCH,
        S_DIVIDE
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [VW-1:0]       r_cand;
    logic [VW-1:0]       r_prime;
    logic                r_res_valid;
    logic                r_flag_out;
    logic [1:0]          r_status;

    logic                req_take;
    logic [VW-1:0]       req_val;
    logic                wr_en;
    logic                rd_en;
    logic [VW-1:0]       rd_data;
    logic                div_start;
    sdm_pkg::t_rem_stat  rem_stat;
    logic                hit;
    logic                last;

    // request handshake
    assign i_req.ready = (r_state == S_IDLE) && (!r_res_valid || o_res.ready);
    assign req_take    = i_req.valid && i_req.ready;
    assign req_val     = i_req.item_value[VW-1:0];

    // table write on an accepted append of a value of 2 or more, with room
    assign wr_en = req_take && (i_req.mode == sdm_pkg::MODE_APPEND)
                   && (req_val >= VW'(sdm_pkg::MIN_PRIME))
                   && (r_count < CW'(MAX_PRIMES));

    assign rd_en     = (r_state == S_READ);
    assign div_start = (r_state == S_FETCH);

    // divisibility check once the remainder is known
    assign hit  = rem_stat.zero && (r_cand > r_prime);
    assign last = ((r_idx + CW'(1)) == r_count);

    sdm_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_PRIMES),
        .ADDR_W(AW)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_count[AW-1:0]),
        .i_wr_data(req_val),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_idx[AW-1:0]),
        .o_rd_data(rd_data)
    );

    sdm_rem #(
        .VW(VW)
    ) u_rem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(r_cand),
        .i_divisor (rd_data),
        .o_stat    (rem_stat)
    );

    // sequencer, table count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (r_res_valid && o_res.ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_flag_out <= 1'b0;
                        r_status   <= sdm_pkg::ST_OK;
                        case (i_req.mode)
                            sdm_pkg::MODE_CLEAR: begin
                                r_count     <= '0;
                                r_res_valid <= 1'b1;
                            end
                            sdm_pkg::MODE_APPEND: begin
                                r_res_valid <= 1'b1;
                                if (req_val < VW'(sdm_pkg::MIN_PRIME)) begin
                                    r_status <= sdm_pkg::ST_LOW;
                                end else if (r_count >= CW'(MAX_PRIMES)) begin
                                    r_status <= sdm_pkg::ST_FULL;
                                end else begin
                                    r_count <= r_count + CW'(1);
                                end
                            end
                            sdm_pkg::MODE_TEST: begin
                                if (i_req.flag_in && (r_count != '0)) begin
                                    r_cand  <= req_val;
                                    r_idx   <= '0;
                                    r_state <= S_READ;
                                end else begin
                                    r_flag_out  <= i_req.flag_in;
                                    r_res_valid <= 1'b1;
                                end
                            end
                            default: begin
                                r_res_valid <= 1'b1;
                            end
                        endcase
                    end
                end
                S_READ: begin
                    r_state <= S_FETCH;
                end
                S_FETCH: begin
                    r_prime <= rd_data;
                    r_state <= S_DIVIDE;
                end
                S_DIVIDE: begin
                    if (rem_stat.done) begin
                        if (hit || last) begin
                            r_flag_out  <= !hit;
                            r_status    <= sdm_pkg::ST_OK;
                            r_res_valid <= 1'b1;
                            r_state     <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + CW'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid    = r_res_valid;
    assign o_res.flag_out = r_flag_out;
    assign o_res.status   = r_status;

`ifndef SYNTHESIS
    // table count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_PRIMES))
        else $error("prime count beyond table depth");

    // a walk only visits filled entries
    a_walk_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_idx < r_count))
        else $error("walk index past prime count");

    // remainder unit finishes only while the sequencer waits for it
    a_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.done |-> (r_state == S_DIVIDE))
        else $error("remainder done outside divide state");

    // no result is produced while the remainder unit is running
    a_busy_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rem_stat.busy |-> (!r_res_valid && (r_state == S_DIVIDE)))
        else $error("result pending during remainder walk");

    // test on an empty table passes the flag straight through
    a_empty_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_take && (i_req.mode == sdm_pkg::MODE_TEST) && (r_count == '0))
        |=> (r_res_valid && (r_flag_out == $past(i_req.flag_in))))
        else $error("empty table test did not pass the flag");
`endif

endmodule

// ===== tb/testbench.sv =====
// testbench: self-checking bench for the sieve divisor marker, with its own prime table
// depends on sdm_pkg, sdm_req_if / sdm_res_if and sieve_divisor_marker

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH = 64;
    localparam logic [1:0]  MODE_UNUSED = 2'd3;
    localparam int unsigned IDLE_LIMIT  = 20000;
    localparam int unsigned LONG_HOLD   = 300;
    localparam int unsigned DRAIN_WAIT  = 40;

    typedef struct packed {
        logic       flag_out;
        logic [1:0] status;
    } t_mark;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_style;

    logic i_clk;
    logic i_rst_n;

    sdm_req_if req_ch ();
    sdm_res_if res_ch ();

    sieve_divisor_marker #(
        .MAX_PRIMES (TABLE_DEPTH),
        .VALUE_BITS (32)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    // shadow of the block state
    logic [31:0] shadow_primes [0:TABLE_DEPTH-1];
    logic [6:0]  shadow_count;

    t_mark       pending_marks [$];
    int unsigned fail_count;
    int unsigned burst_left;
    logic        long_hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // a candidate is struck when a smaller stored prime divides it
    function automatic logic divisor_found(input logic [31:0] cand);
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_primes[i] >= sdm_pkg::MIN_PRIME && cand > shadow_primes[i]
                    && (cand % shadow_primes[i]) == 32'd0)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // predicted result of one request, updating the shadow table
    function automatic t_mark sieve_predict(input logic [1:0] mode, input logic [31:0] value,
                                            input logic flag);
        t_mark res;
        res = '0;
        res.status = sdm_pkg::ST_OK;
        case (mode)
            sdm_pkg::MODE_CLEAR: begin
                shadow_count = '0;
            end
            sdm_pkg::MODE_APPEND: begin
                if (value < sdm_pkg::MIN_PRIME) begin
                    res.status = sdm_pkg::ST_LOW;
                end else if (shadow_count >= TABLE_DEPTH) begin
                    res.status = sdm_pkg::ST_FULL;
                end else begin
                    shadow_primes[shadow_count] = value;
                    shadow_count = shadow_count + 7'd1;
                end
            end
            sdm_pkg::MODE_TEST: begin
                if (flag)
                    res.flag_out = ~divisor_found(value);
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // offer one request in bursts with random gaps, predict once it is taken
    task automatic send_request(input logic [1:0] mode, input logic [31:0] value,
                                input logic flag);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            if (gap != 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= mode;
        req_ch.item_value <= value;
        req_ch.flag_in    <= flag;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        pending_marks.push_back(sieve_predict(mode, value, flag));
        burst_left--;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_mark exp_mark;
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (pending_marks.size() == 0) begin
                $error("result with no request outstanding: flag_out %0b status %0d",
                       res_ch.flag_out, res_ch.status);
                fail_count++;
            end else begin
                exp_mark = pending_marks.pop_front();
                if (res_ch.flag_out !== exp_mark.flag_out) begin
                    $error("flag_out: expected %0b, actual %0b",
                           exp_mark.flag_out, res_ch.flag_out);
                    fail_count++;
                end
                if (res_ch.status !== exp_mark.status) begin
                    $error("status: expected %0d, actual %0d", exp_mark.status, res_ch.status);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge i_clk) begin
        int unsigned idle_cycles;
        if (!i_rst_n || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
                || (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // receiver: segments of steady, random and sparse ready, plus long holds on request
    initial begin
        int unsigned seg_left;
        int unsigned hold_left;
        t_rx_style   style;
        seg_left  = 0;
        hold_left = 0;
        style     = RX_STEADY;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else begin
                if (seg_left == 0) begin
                    style    = t_rx_style'($urandom_range(0, 2));
                    seg_left = $urandom_range(16, 80);
                end
                seg_left--;
                case (style)
                    RX_STEADY: res_ch.ready <= 1'b1;
                    RX_RANDOM: res_ch.ready <= 1'($urandom_range(0, 1));
                    default:   res_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // extremes of the fields and every special case on a small table
    task automatic test_directed();
        send_request(sdm_pkg::MODE_TEST, 32'd0, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'hFFFF_FFFF, 1'b1);
        send_request(sdm_pkg::MODE_APPEND, 32'd0, 1'b0);
        send_request(sdm_pkg::MODE_APPEND, 32'd1, 1'b1);
        send_request(sdm_pkg::MODE_APPEND, 32'd2, 1'b0);
        send_request(sdm_pkg::MODE_APPEND, 32'd3, 1'b1);
        send_request(sdm_pkg::MODE_APPEND, 32'd5, 1'b0);
        send_request(sdm_pkg::MODE_APPEND, 32'hFFFF_FFFB, 1'b0);
        send_request(sdm_pkg::MODE_TEST, 32'd4, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'd2, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'd25, 1'b0);
        send_request(sdm_pkg::MODE_TEST, 32'd7, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'hFFFF_FFFF, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'hFFFF_FFFE, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'hFFFF_FFFB, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'd0, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'd1, 1'b1);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF, 1'b1);
        send_request(sdm_pkg::MODE_CLEAR, 32'hFFFF_FFFF, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'd4, 1'b1);
        send_request(sdm_pkg::MODE_APPEND, 32'h8000_0000, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'hFFFF_FFFF, 1'b1);
    endtask

    // fill the table, then overflow it and walk it end to end
    task automatic test_full_table();
        send_request(sdm_pkg::MODE_CLEAR, 32'd0, 1'b0);
        for (int k = 0; k < TABLE_DEPTH; k++)
            send_request(sdm_pkg::MODE_APPEND, 32'd101 + 32'(2 * k), 1'b0);
        send_request(sdm_pkg::MODE_APPEND, 32'd7, 1'b0);
        send_request(sdm_pkg::MODE_APPEND, 32'd1, 1'b0);
        send_request(sdm_pkg::MODE_APPEND, 32'd0, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'hFFFF_FFFB, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'd681, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'd227, 1'b1);
        send_request(sdm_pkg::MODE_TEST, 32'd10201, 1'b1);
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        long_hold_req = 1'b1;
        burst_left    = 40;
        send_request(sdm_pkg::MODE_CLEAR, $urandom, 1'b0);
        for (int k = 0; k < 20; k++)
            send_request((k % 3 == 2) ? sdm_pkg::MODE_TEST : sdm_pkg::MODE_APPEND,
                         $urandom_range(2, 40), 1'($urandom_range(0, 1)));
    endtask

    // random sieve sequences: clear, load some primes, test candidates, some noise
    task automatic test_random_sequences(input int unsigned n_items);
        int unsigned sent;
        int unsigned loads;
        int unsigned cands;
        int unsigned max_mult;
        logic [31:0] pick;
        logic [31:0] cand;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                send_request(sdm_pkg::MODE_CLEAR, $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end
            loads = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 70)
                                                 : $urandom_range(0, 8);
            for (int k = 0; k < loads; k++) begin
                case ($urandom_range(0, 9))
                    0:       pick = $urandom_range(0, 1);
                    1:       pick = $urandom;
                    default: pick = $urandom_range(2, 60);
                endcase
                send_request(sdm_pkg::MODE_APPEND, pick, 1'($urandom_range(0, 1)));
                sent++;
            end
            cands = $urandom_range(2, 10);
            for (int k = 0; k < cands; k++) begin
                cand = $urandom;
                if (shadow_count != 0) begin
                    pick = shadow_primes[$urandom_range(0, shadow_count - 1)];
                    case ($urandom_range(0, 7))
                        0, 1, 2: begin
                            max_mult = 32'hFFFF_FFFF / pick;
                            cand = (max_mult >= 2) ? pick * $urandom_range(2, max_mult) : pick;
                        end
                        3:       cand = pick;
                        4:       cand = pick + 32'd1;
                        default: cand = $urandom;
                    endcase
                end
                send_request(sdm_pkg::MODE_TEST, cand, $urandom_range(0, 7) != 0);
                sent++;
            end
            // unused mode, ignored by the block
            if ($urandom_range(0, 4) == 0) begin
                send_request(MODE_UNUSED, $urandom, 1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // main sequence
    initial begin
        shadow_count  = '0;
        fail_count    = 0;
        burst_left    = 0;
        long_hold_req = 1'b0;
        i_rst_n           <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= sdm_pkg::MODE_CLEAR;
        req_ch.item_value <= '0;
        req_ch.flag_in    <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_backpressure();
        test_random_sequences(170);
        req_ch.valid <= 1'b0;

        while (pending_marks.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
